// ===== rtl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared types, constants and register indexes for the ranging sequencer.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Sequencer geometry.
  localparam int Samples   = 5;
  localparam int EchoBits  = 16;
  localparam int SumBits   = EchoBits + 3;
  localparam int TimerBits = 10;
  localparam int RoundBits = 3;
  localparam int TrigBits  = 8;
  localparam int SettleBits = 10;
  localparam int DistBits  = 15;

  // Configuration port.
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 10;
  localparam logic [CfgIdxBits-1:0] REG_TRIGGER_WIDTH = 1'd0;
  localparam logic [CfgIdxBits-1:0] REG_SETTLE        = 1'd1;

  // Stream words.
  localparam int InDataBits  = 8;
  localparam int OutDataBits = 24;

  // Distance scaling: floor(sum * 16 / (58 * Samples)) by a reciprocal multiply.
  // With the shift below the rounded-up reciprocal is exact over the whole sum range.
  localparam int    CmDivisor  = 58;
  localparam int    DistDiv    = CmDivisor * Samples;
  localparam int    ScaledBits = SumBits + 4;
  localparam int    RecipShift = 32;
  localparam longint RecipL    = ((64'd1 << RecipShift) + DistDiv - 1) / DistDiv;
  localparam int    RecipBits  = $clog2(RecipL + 1);
  localparam logic [RecipBits-1:0] Recip = RecipL[RecipBits-1:0];
  localparam int    ProdBits   = ScaledBits + RecipBits;

  localparam logic [EchoBits-1:0] EchoMax = {EchoBits{1'b1}};
  localparam logic [SumBits-1:0]  SumMax  = {SumBits{1'b1}};
  localparam logic [RoundBits-1:0] SamplesCnt = RoundBits'(Samples);

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_TRIG   = 3'd1,
    PH_RISE   = 3'd2,
    PH_COUNT  = 3'd3,
    PH_SETTLE = 3'd4
  } phase_t;

  // Per-tick result of the sequencer, before distance scaling.
  typedef struct packed {
    logic               trig;
    logic               busy;
    logic               report;
    logic [SumBits-1:0] sum;
  } seq_res_t;

endpackage

// ===== rtl/ultrasonic_echo_ranger_top.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Ranging sequencer for a trigger/echo ultrasonic sensor, one word per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave word is one microsecond tick carrying a start command and the
//   sampled echo level. Every accepted word yields exactly one master word with
//   the trigger drive, the busy flag, a report flag and the averaged distance.
//   A start while a measurement is running is ignored.
//   The configuration channel writes the trigger width (index 0) and the settle
//   time (index 1); it is always ready and should be written while idle.
// Throughput and pipeline:
//   One word per cycle is accepted while the master side is not stalled. A result
//   passes through the sequencer result register and then through the distance
//   multiply and output register before it appears on the master side.
// Reset:
//   Synchronous reset returns the sequencer to idle, loads the default trigger
//   width of 20 and settle time of 50, and empties the output pipeline.
// Stalls:
//   When the master side is stalled the two pipeline stages fill and the slave
//   side then deasserts tready; no word is lost or repeated.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // Slave stream: bit 0 command, bit 1 echo_level, rest zero.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [uer_pkg::InDataBits-1:0]       s_axis_tdata,
  // Master stream: bit 0 trigger_level, bit 1 busy_res, bit 2 result_valid,
  // bits 17:3 distance_q4, rest zero.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [uer_pkg::OutDataBits-1:0]      m_axis_tdata,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [uer_pkg::CfgIdxBits-1:0]       cfg_index,
  input  logic [uer_pkg::CfgDataBits-1:0]      cfg_data
);

  logic [uer_pkg::TrigBits-1:0]    trigger_width_us;
  logic [uer_pkg::SettleBits-1:0]  settle_us;
  logic                            step;
  logic                            adv_out;
  logic                            adv_mid;
  uer_pkg::seq_res_t               seq_res;
  uer_pkg::seq_res_t               mid;
  logic                            mid_valid;
  logic [uer_pkg::DistBits-1:0]    distance_q4;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_width_us <= uer_pkg::TrigBits'(20);
      settle_us        <= uer_pkg::SettleBits'(50);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        uer_pkg::REG_TRIGGER_WIDTH: trigger_width_us <= cfg_data[uer_pkg::TrigBits-1:0];
        uer_pkg::REG_SETTLE:        settle_us        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control: each stage moves when the one after it can take a word.
  assign adv_out       = !m_axis_tvalid || m_axis_tready;
  assign adv_mid       = !mid_valid || adv_out;
  assign s_axis_tready = adv_mid;
  assign step          = s_axis_tvalid && s_axis_tready;

  uer_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .command          (s_axis_tdata[0]),
    .echo_level       (s_axis_tdata[1]),
    .trigger_width_us (trigger_width_us),
    .settle_us        (settle_us),
    .res              (seq_res)
  );

  // Sequencer result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (adv_mid) begin
      mid_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_mid) begin
      mid <= seq_res;
    end
  end

  uer_dist u_dist (
    .sum         (mid.sum),
    .report      (mid.report),
    .distance_q4 (distance_q4)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv_out) begin
      m_axis_tvalid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      m_axis_tdata <= {6'b000000, distance_q4, mid.report, mid.busy, mid.trig};
    end
  end

endmodule

// ===== rtl/uer_seq.sv =====
// ----------------------------------------------------------------------------
// Ranging sequencer
// Holds the phase, timers and echo accumulators; advances once per accepted tick.
// ----------------------------------------------------------------------------
module uer_seq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic                               command,
  input  logic                               echo_level,
  input  logic [uer_pkg::TrigBits-1:0]       trigger_width_us,
  input  logic [uer_pkg::SettleBits-1:0]     settle_us,
  output uer_pkg::seq_res_t                  res
);

  uer_pkg::phase_t                    phase, phase_next;
  logic [uer_pkg::TimerBits-1:0]      step_timer, step_timer_next;
  logic [uer_pkg::EchoBits-1:0]       echo_time, echo_time_next;
  logic [uer_pkg::SumBits-1:0]        echo_sum, echo_sum_next;
  logic [uer_pkg::RoundBits-1:0]      rounds_done, rounds_done_next;
  logic [uer_pkg::TimerBits-1:0]      timer_inc;
  logic [uer_pkg::SumBits:0]          sum_wide;
  logic                               report;

  assign timer_inc = step_timer + uer_pkg::TimerBits'(1);
  assign sum_wide  = {1'b0, echo_sum} + (uer_pkg::SumBits + 1)'(echo_time);

  // Next-state logic for the phase and the counters.
  always_comb begin
    phase_next       = phase;
    step_timer_next  = step_timer;
    echo_time_next   = echo_time;
    echo_sum_next    = echo_sum;
    rounds_done_next = rounds_done;
    report           = 1'b0;
    case (phase)
      uer_pkg::PH_IDLE: begin
        if (command) begin
          phase_next       = uer_pkg::PH_TRIG;
          step_timer_next  = '0;
          echo_time_next   = '0;
          echo_sum_next    = '0;
          rounds_done_next = '0;
        end
      end
      uer_pkg::PH_TRIG: begin
        step_timer_next = timer_inc;
        if (timer_inc >= uer_pkg::TimerBits'(trigger_width_us)) begin
          phase_next      = uer_pkg::PH_RISE;
          step_timer_next = '0;
        end
      end
      uer_pkg::PH_RISE: begin
        if (echo_level) begin
          echo_time_next = uer_pkg::EchoBits'(1);
          phase_next     = uer_pkg::PH_COUNT;
        end
      end
      uer_pkg::PH_COUNT: begin
        if (echo_level) begin
          if (echo_time != uer_pkg::EchoMax) begin
            echo_time_next = echo_time + uer_pkg::EchoBits'(1);
          end
        end else begin
          // Echo fell: accumulate this round, then settle or close the round.
          echo_sum_next    = sum_wide[uer_pkg::SumBits] ? uer_pkg::SumMax
                                                        : sum_wide[uer_pkg::SumBits-1:0];
          rounds_done_next = rounds_done + uer_pkg::RoundBits'(1);
          step_timer_next  = '0;
          if (settle_us == '0) begin
            if (rounds_done_next >= uer_pkg::SamplesCnt) begin
              phase_next = uer_pkg::PH_IDLE;
              report     = 1'b1;
            end else begin
              phase_next = uer_pkg::PH_TRIG;
            end
          end else begin
            phase_next = uer_pkg::PH_SETTLE;
          end
        end
      end
      uer_pkg::PH_SETTLE: begin
        step_timer_next = timer_inc;
        if (timer_inc >= settle_us) begin
          step_timer_next = '0;
          if (rounds_done >= uer_pkg::SamplesCnt) begin
            phase_next = uer_pkg::PH_IDLE;
            report     = 1'b1;
          end else begin
            phase_next = uer_pkg::PH_TRIG;
          end
        end
      end
      default: begin
        phase_next      = uer_pkg::PH_IDLE;
        step_timer_next = '0;
      end
    endcase
  end

  // Per-tick outputs.
  always_comb begin
    res.trig   = (phase == uer_pkg::PH_TRIG);
    res.busy   = (phase_next != uer_pkg::PH_IDLE);
    res.report = report;
    res.sum    = echo_sum_next;
  end

  // State registers advance only on an accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= uer_pkg::PH_IDLE;
      step_timer  <= '0;
      echo_time   <= '0;
      echo_sum    <= '0;
      rounds_done <= '0;
    end else if (step) begin
      phase       <= phase_next;
      step_timer  <= step_timer_next;
      echo_time   <= echo_time_next;
      echo_sum    <= echo_sum_next;
      rounds_done <= rounds_done_next;
    end
  end

endmodule

// ===== rtl/uer_dist.sv =====
// ----------------------------------------------------------------------------
// Distance scaler
// Converts the echo sum to averaged centimetres in Q11.4 by reciprocal multiply.
// ----------------------------------------------------------------------------
module uer_dist (
  input  logic [uer_pkg::SumBits-1:0]   sum,
  input  logic                          report,
  output logic [uer_pkg::DistBits-1:0]  distance_q4
);

  logic [uer_pkg::ScaledBits-1:0] scaled;
  logic [uer_pkg::ProdBits-1:0]   prod;
  logic [uer_pkg::ProdBits-1:0]   quot;
  logic                           over;

  // sum * 16, then multiply by the rounded-up reciprocal of the divisor.
  assign scaled = {sum, 4'b0000};
  assign prod   = uer_pkg::ProdBits'(scaled) * uer_pkg::ProdBits'(uer_pkg::Recip);
  assign quot   = prod >> uer_pkg::RecipShift;
  assign over   = |(quot >> uer_pkg::DistBits);

  // Saturate and zero the field when no report is due.
  always_comb begin
    if (!report) begin
      distance_q4 = '0;
    end else if (over) begin
      distance_q4 = {uer_pkg::DistBits{1'b1}};
    end else begin
      distance_q4 = quot[uer_pkg::DistBits-1:0];
    end
  end

endmodule

// ===== dv/tb_ultrasonic_echo_ranger_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger testbench
// Drives microsecond tick words into the ranger, shaped as trigger/echo rounds
// with random content. A cycle-level predictor computes the expected master
// word for every accepted tick, and a checker compares each returned word
// field by field. Both stream sides idle at random, and one stretch holds the
// master side off long enough to stall the slave side.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger_top;

  localparam int CycleLimit = 3_000_000;
  localparam int DrainPad   = 8;
  localparam int HoldCycles = 400;
  localparam longint unsigned DistMax = (64'd1 << uer_pkg::DistBits) - 64'd1;

  // One master word as the predictor sees it.
  typedef struct packed {
    logic                         trig;
    logic                         busy;
    logic                         reported;
    logic [uer_pkg::DistBits-1:0] distance;
  } ranger_word_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [uer_pkg::InDataBits-1:0]  s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [uer_pkg::OutDataBits-1:0] m_axis_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [uer_pkg::CfgIdxBits-1:0]  cfg_index;
  logic [uer_pkg::CfgDataBits-1:0] cfg_data;

  // Predictor state and its copy of the registers.
  uer_pkg::phase_t                ph         = uer_pkg::PH_IDLE;
  logic [uer_pkg::TimerBits-1:0]  tmr        = '0;
  logic [uer_pkg::EchoBits-1:0]   etime      = '0;
  logic [uer_pkg::SumBits-1:0]    esum       = '0;
  logic [uer_pkg::RoundBits-1:0]  rounds     = '0;
  logic [uer_pkg::TrigBits-1:0]   trig_width = 8'd20;
  logic [uer_pkg::SettleBits-1:0] settle     = 10'd50;

  ranger_word_t due_words[$];
  int mismatches  = 0;
  int ticks_sent  = 0;
  longint cycles  = 0;

  // Idling controls shared with the stimulus.
  int tx_max_gap    = 0;
  int tx_burst_left = 0;
  int rx_max_stall  = 0;
  bit hold_request  = 1'b0;

  ultrasonic_echo_ranger_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Closes a round after its settle, or when the echo falls with no settle; returns 1 when the distance is due.
  function automatic logic close_round();
    tmr = '0;
    if (int'(rounds) >= uer_pkg::Samples) begin
      ph = uer_pkg::PH_IDLE;
      return 1'b1;
    end
    ph = uer_pkg::PH_TRIG;
    return 1'b0;
  endfunction

  // Advances the sequencer by one tick and returns the expected master word.
  function automatic ranger_word_t step_ranger(input logic cmd, input logic echo);
    ranger_word_t w;
    logic rep;
    logic [uer_pkg::SumBits:0] wide_sum;
    longint unsigned q;
    w   = '0;
    rep = 1'b0;
    case (ph)
      uer_pkg::PH_IDLE: begin
        if (cmd) begin
          ph     = uer_pkg::PH_TRIG;
          tmr    = '0;
          etime  = '0;
          esum   = '0;
          rounds = '0;
        end
      end
      uer_pkg::PH_TRIG: begin
        w.trig = 1'b1;
        tmr = tmr + 1'b1;
        // A zero width still gives one trigger tick.
        if (tmr >= trig_width) begin
          ph  = uer_pkg::PH_RISE;
          tmr = '0;
        end
      end
      uer_pkg::PH_RISE: begin
        if (echo) begin
          etime = uer_pkg::EchoBits'(1);
          ph    = uer_pkg::PH_COUNT;
        end
      end
      uer_pkg::PH_COUNT: begin
        if (echo) begin
          if (etime != uer_pkg::EchoMax) etime = etime + 1'b1;
        end else begin
          wide_sum = {1'b0, esum} + (uer_pkg::SumBits + 1)'(etime);
          esum     = wide_sum[uer_pkg::SumBits] ? uer_pkg::SumMax
                                                : wide_sum[uer_pkg::SumBits-1:0];
          rounds   = rounds + 1'b1;
          tmr      = '0;
          if (settle == '0) rep = close_round();
          else ph = uer_pkg::PH_SETTLE;
        end
      end
      uer_pkg::PH_SETTLE: begin
        tmr = tmr + 1'b1;
        if (tmr >= settle) rep = close_round();
      end
      default: begin
        ph  = uer_pkg::PH_IDLE;
        tmr = '0;
      end
    endcase
    w.busy     = (ph != uer_pkg::PH_IDLE);
    w.reported = rep;
    if (rep) begin
      q = 64'(esum);
      q = (q * 64'd16) / 64'(uer_pkg::CmDivisor * uer_pkg::Samples);
      if (q > DistMax) q = DistMax;
      w.distance = q[uer_pkg::DistBits-1:0];
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Checks every word taken from the master side against the oldest expectation.
  always @(posedge clk) begin
    ranger_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_words.size() == 0) begin
        report_mismatch("unexpected word", 64'(m_axis_tdata), 64'd0);
      end else begin
        want = due_words.pop_front();
        if (m_axis_tdata[0] !== want.trig)
          report_mismatch("trigger_level", 64'(m_axis_tdata[0]), 64'(want.trig));
        if (m_axis_tdata[1] !== want.busy)
          report_mismatch("busy_res", 64'(m_axis_tdata[1]), 64'(want.busy));
        if (m_axis_tdata[2] !== want.reported)
          report_mismatch("result_valid", 64'(m_axis_tdata[2]), 64'(want.reported));
        if (m_axis_tdata[3 +: uer_pkg::DistBits] !== want.distance)
          report_mismatch("distance_q4", 64'(m_axis_tdata[3 +: uer_pkg::DistBits]),
                          64'(want.distance));
        if (m_axis_tdata[uer_pkg::OutDataBits-1:3+uer_pkg::DistBits] !== '0)
          report_mismatch("padding",
                          64'(m_axis_tdata[uer_pkg::OutDataBits-1:3+uer_pkg::DistBits]),
                          64'd0);
      end
    end
  end

  // Master side: random ready and stall runs, or a long hold-off on request.
  initial begin
    int   rx_run;
    logic rx_level;
    rx_run   = 0;
    rx_level = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        if (rx_run == 0) begin
          if (rx_max_stall == 0) begin
            rx_level = 1'b1;
            rx_run   = 16;
          end else if (rx_level) begin
            rx_level = 1'b0;
            rx_run   = $urandom_range(1, rx_max_stall);
          end else begin
            rx_level = 1'b1;
            rx_run   = $urandom_range(1, 24);
          end
        end
        m_axis_tready <= rx_level;
        rx_run--;
      end
    end
  end

  // Offers one tick word, with a random gap at the start of each burst.
  task automatic send_tick(input logic cmd, input logic echo);
    ranger_word_t w;
    int gap;
    @(negedge clk);
    if (tx_max_gap != 0 && tx_burst_left == 0) begin
      gap = $urandom_range(1, tx_max_gap);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
      tx_burst_left = $urandom_range(1, 24);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= uer_pkg::InDataBits'({echo, cmd});
    do @(posedge clk); while (!s_axis_tready);
    w = step_ranger(cmd, echo);
    due_words.push_back(w);
    ticks_sent++;
  endtask

  // Stops offering words and waits for every expected word to come back.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (DrainPad) @(posedge clk);
  endtask

  // Writes one register; only called with the block drained and idle.
  task automatic write_reg(input logic [uer_pkg::CfgIdxBits-1:0] idx,
                           input logic [uer_pkg::CfgDataBits-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      uer_pkg::REG_TRIGGER_WIDTH: trig_width = value[uer_pkg::TrigBits-1:0];
      uer_pkg::REG_SETTLE:        settle     = value[uer_pkg::SettleBits-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input logic [uer_pkg::CfgDataBits-1:0] trig_value,
                            input logic [uer_pkg::CfgDataBits-1:0] settle_value);
    write_reg(uer_pkg::REG_TRIGGER_WIDTH, trig_value);
    write_reg(uer_pkg::REG_SETTLE, settle_value);
  endtask

  // Runs one full measurement from idle. The echo rises after a random wait
  // and stays high for a random length. noise_pct sets how often starts
  // arrive while busy and how often the echo toggles while it is ignored.
  task automatic measure(input int rise_hi, input int len_lo, input int len_hi,
                         input int noise_pct);
    int   rise_left;
    int   high_left;
    int   len;
    logic cmd;
    logic echo;
    rise_left = 0;
    high_left = 0;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    while (ph != uer_pkg::PH_IDLE) begin
      cmd  = ($urandom_range(0, 99) < noise_pct);
      echo = 1'b0;
      case (ph)
        uer_pkg::PH_TRIG: begin
          echo      = ($urandom_range(0, 99) < noise_pct);
          rise_left = $urandom_range(0, rise_hi);
          len       = $urandom_range(len_lo, len_hi);
          high_left = len - 1;
        end
        uer_pkg::PH_RISE: begin
          if (rise_left > 0) rise_left--;
          else echo = 1'b1;
        end
        uer_pkg::PH_COUNT: begin
          if (high_left > 0) begin
            echo = 1'b1;
            high_left--;
          end
        end
        uer_pkg::PH_SETTLE: echo = ($urandom_range(0, 99) < noise_pct);
        default: ;
      endcase
      send_tick(cmd, echo);
    end
  endtask

  // Ticks that leave the idle block alone.
  task automatic idle_ticks(input int n);
    repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  // Registers at their reset values of 20 and 50.
  task automatic test_reset_defaults();
    idle_ticks(4);
    measure(3, 5, 30, 0);
    drain();
  endtask

  // Shortest rounds (one trigger tick, one echo tick, no settle), then short rounds with no settle.
  task automatic test_short_rounds();
    set_timing(10'd1, 10'd0);
    measure(0, 1, 1, 0);
    measure(2, 1, 3, 0);
    drain();
  endtask

  // A zero trigger width behaves as a width of one.
  task automatic test_trigger_width_zero();
    set_timing(10'd0, 10'd1);
    measure(2, 1, 6, 20);
    drain();
  endtask

  // The trigger width is written with the unused upper data bits set; only
  // the low byte counts.
  task automatic test_width_truncation();
    set_timing(10'h302, 10'd9);
    measure(4, 2, 10, 30);
    drain();
  endtask

  // Starts arrive on every busy tick and the echo toggles during trigger and
  // settle; all of it must be ignored.
  task automatic test_start_while_busy();
    set_timing(10'd3, 10'd4);
    measure(3, 1, 8, 100);
    drain();
  endtask

  // The master side holds off while the slave side keeps offering words.
  task automatic test_backpressure();
    set_timing(10'd2, 10'd3);
    tx_max_gap   = 0;
    rx_max_stall = 0;
    hold_request = 1'b1;
    measure(3, 2, 12, 10);
    measure(1, 1, 5, 10);
    drain();
  endtask

  // Random settings, idling and measurement content.
  task automatic test_random();
    int tick_goal;
    int runs;
    logic [uer_pkg::TrigBits-1:0]   tw;
    logic [uer_pkg::SettleBits-1:0] st;
    tick_goal = ticks_sent + 1100;
    runs      = 0;
    while (ticks_sent < tick_goal) begin
      if (runs % 5 == 0) begin
        drain();
        tw = 8'($urandom_range(0, 6));
        st = 10'($urandom_range(0, 6));
        write_reg(uer_pkg::REG_TRIGGER_WIDTH, {2'($urandom_range(0, 3)), tw});
        write_reg(uer_pkg::REG_SETTLE, st);
      end
      // Some stretches run with no idling on either side.
      tx_max_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      rx_max_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      idle_ticks($urandom_range(0, 3));
      measure($urandom_range(0, 4), 1, $urandom_range(1, 10), $urandom_range(0, 30));
      runs++;
    end
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_short_rounds();
    test_trigger_width_zero();
    test_width_truncation();
    test_start_while_busy();
    test_backpressure();
    test_random();

    drain();
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/uer_pkg.sv
rtl/uer_seq.sv
rtl/uer_dist.sv
rtl/ultrasonic_echo_ranger_top.sv
dv/tb_ultrasonic_echo_ranger_top.sv
